// File: design/brle_pkg.sv
// Shared types, constants and helpers for the bitmap RLE8/RLE4 decoder.
// No dependencies; brle_step and bitmap_rle_decoder import this package.
package brle_pkg;

    localparam logic [12:0] MAX_WIDTH   = 13'd4096;
    localparam logic [12:0] MAX_HEIGHT  = 13'd4096;
    localparam logic [7:0]  NIBBLE_MASK = 8'h0F;

    // escape commands that follow a zero count byte
    localparam logic [7:0] ESC_END_LINE  = 8'd0;
    localparam logic [7:0] ESC_END_IMAGE = 8'd1;
    localparam logic [7:0] ESC_DELTA     = 8'd2;

    typedef logic [1:0]  t_cfg_index;
    typedef logic [12:0] t_cfg_data;

    localparam t_cfg_index CFG_IMAGE_WIDTH  = 2'd0;
    localparam t_cfg_index CFG_IMAGE_HEIGHT = 2'd1;
    localparam t_cfg_index CFG_PIXEL_MODE   = 2'd2;

    typedef enum logic [6:0] {
        PH_COUNT = 7'b0000001,
        PH_CMD   = 7'b0000010,
        PH_DX    = 7'b0000100,
        PH_DY    = 7'b0001000,
        PH_ABS   = 7'b0010000,
        PH_PAD   = 7'b0100000,
        PH_DONE  = 7'b1000000
    } t_phase;

    typedef struct packed {
        t_phase      phase;
        logic [7:0]  held_count;
        logic [12:0] column_pos;
        logic [12:0] row_pos;
        logic [7:0]  absolute_left;
        logic        pad_pending;
        logic [7:0]  delta_dx;
    } t_state;

    localparam t_state STATE_RESET = '{
        phase:         PH_COUNT,
        held_count:    8'd0,
        column_pos:    13'd0,
        row_pos:       13'd0,
        absolute_left: 8'd0,
        pad_pending:   1'b0,
        delta_dx:      8'd0
    };

    typedef struct packed {
        logic [11:0] span_column;
        logic [11:0] span_row;
        logic [7:0]  span_length;
        logic [7:0]  even_index;
        logic [7:0]  odd_index;
        logic        image_done;
    } t_span;

    // clamp a configured size to the supported maximum
    function automatic logic [12:0] eff_limit(input logic [12:0] value,
                                              input logic [12:0] limit);
        return (value > limit) ? limit : value;
    endfunction

endpackage

// File: design/brle_in_if.sv
// Input channel of the decoder: one compressed stream byte per request.
// Depends on nothing but the handshake convention valid/ready.
interface brle_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] stream_byte;
    logic       last_byte;

    modport source (output valid, output stream_byte, output last_byte, input ready);
    modport sink   (input valid, input stream_byte, input last_byte, output ready);
endinterface

// File: design/brle_out_if.sv
// Output channel of the decoder: one pixel span per request.
// Depends on nothing but the handshake convention valid/ready.
interface brle_out_if;
    logic        valid;
    logic        ready;
    logic [11:0] span_column;
    logic [11:0] span_row;
    logic [7:0]  span_length;
    logic [7:0]  even_index;
    logic [7:0]  odd_index;
    logic        image_done;

    modport source (output valid, output span_column, output span_row,
                    output span_length, output even_index, output odd_index,
                    output image_done, input ready);
    modport sink   (input valid, input span_column, input span_row,
                    input span_length, input even_index, input odd_index,
                    input image_done, output ready);
endinterface

// File: design/brle_cfg_if.sv
// Configuration write channel of the decoder: register index plus data.
// Depends on nothing but the handshake convention valid/ready.
interface brle_cfg_if;
    logic        valid;
    logic        ready;
    logic [1:0]  cfg_index;
    logic [12:0] cfg_data;

    modport source (output valid, output cfg_index, output cfg_data, input ready);
    modport sink   (input valid, input cfg_index, input cfg_data, output ready);
endinterface

// File: design/brle_step.sv
// Per-byte parse step: next parser state and the span (if any) for one byte.
// Pure combinational logic; uses types and helpers from brle_pkg.
module brle_step (
    input  brle_pkg::t_state i_state,
    input  logic [12:0]      i_width,
    input  logic [12:0]      i_height,
    input  logic             i_mode,
    input  logic [7:0]       i_byte,
    input  logic             i_last,
    output brle_pkg::t_state o_state,
    output brle_pkg::t_span  o_span,
    output logic             o_has_span
);
    import brle_pkg::*;

    logic [12:0] w_eff;
    logic [12:0] h_eff;
    logic [12:0] room;
    logic [7:0]  abs_n;
    logic [7:0]  clip_n;
    logic [7:0]  clip_len;
    logic [12:0] col_adv;
    logic [12:0] dx_sum;
    logic [12:0] row_sum;
    logic [12:0] row_inc;
    logic [8:0]  byte_inc;
    logic [7:0]  left_next;
    logic [7:0]  ev_byte;
    logic [7:0]  od_byte;
    logic        done;
    t_state      st;
    t_span       sp;

    assign w_eff = eff_limit(i_width, MAX_WIDTH);
    assign h_eff = eff_limit(i_height, MAX_HEIGHT);

    // pixels per absolute byte: one in RLE8, up to two in RLE4
    assign abs_n  = i_mode ? ((i_state.absolute_left < 8'd2) ? i_state.absolute_left : 8'd2)
                           : 8'd1;
    assign clip_n = (i_state.phase == PH_ABS) ? abs_n : i_state.held_count;

    // clip against the right edge
    assign room     = w_eff - i_state.column_pos;
    assign clip_len = (i_state.column_pos >= w_eff) ? 8'd0 :
                      (({5'd0, clip_n} < room) ? clip_n : room[7:0]);
    assign col_adv  = i_state.column_pos + {5'd0, clip_len};

    assign dx_sum   = i_state.column_pos + {5'd0, i_state.delta_dx};
    assign row_sum  = i_state.row_pos + {5'd0, i_byte};
    assign row_inc  = i_state.row_pos + 13'd1;
    assign byte_inc = {1'b0, i_byte} + 9'd1;
    assign left_next = (i_state.absolute_left >= abs_n) ? (i_state.absolute_left - abs_n)
                                                        : 8'd0;

    assign ev_byte = i_mode ? ((i_byte >> 4) & NIBBLE_MASK) : i_byte;
    assign od_byte = i_mode ? (i_byte & NIBBLE_MASK) : i_byte;

    always_comb begin
        st   = i_state;
        sp   = '0;
        done = 1'b0;
        o_has_span = 1'b0;

        if (i_state.phase == PH_DONE) begin
            // ignore bytes until the stream's last byte rearms the parser
            if (i_last) begin
                st = STATE_RESET;
            end
        end else begin
            if (i_state.row_pos >= h_eff) begin
                done = 1'b1;
            end else begin
                case (i_state.phase)
                    PH_COUNT: begin
                        st.held_count = i_byte;
                        st.phase      = PH_CMD;
                    end
                    PH_CMD: begin
                        st.phase = PH_COUNT;
                        if (i_state.held_count != 8'd0) begin
                            sp.span_column = i_state.column_pos[11:0];
                            sp.span_row    = i_state.row_pos[11:0];
                            sp.span_length = clip_len;
                            sp.even_index  = ev_byte;
                            sp.odd_index   = od_byte;
                            st.column_pos  = col_adv;
                        end else if (i_byte == ESC_END_LINE) begin
                            st.column_pos = 13'd0;
                            st.row_pos    = row_inc;
                            if (row_inc >= h_eff) begin
                                done = 1'b1;
                            end
                        end else if (i_byte == ESC_END_IMAGE) begin
                            done = 1'b1;
                        end else if (i_byte == ESC_DELTA) begin
                            st.phase = PH_DX;
                        end else begin
                            st.absolute_left = i_byte;
                            // pad when the group used an odd number of bytes
                            st.pad_pending   = i_mode ? byte_inc[1] : i_byte[0];
                            st.phase         = PH_ABS;
                        end
                    end
                    PH_DX: begin
                        st.delta_dx = i_byte;
                        st.phase    = PH_DY;
                    end
                    PH_DY: begin
                        st.column_pos = (dx_sum > w_eff) ? w_eff : dx_sum;
                        if (row_sum >= h_eff) begin
                            st.row_pos = h_eff;
                            done       = 1'b1;
                        end else begin
                            st.row_pos = row_sum;
                        end
                        st.phase = PH_COUNT;
                    end
                    PH_ABS: begin
                        sp.span_column   = i_state.column_pos[11:0];
                        sp.span_row      = i_state.row_pos[11:0];
                        sp.span_length   = clip_len;
                        sp.even_index    = ev_byte;
                        sp.odd_index     = od_byte;
                        st.column_pos    = col_adv;
                        st.absolute_left = left_next;
                        if (left_next == 8'd0) begin
                            st.phase = i_state.pad_pending ? PH_PAD : PH_COUNT;
                        end
                    end
                    default: begin
                        st.phase = PH_COUNT;
                    end
                endcase
            end

            if (i_last) begin
                done = 1'b1;
            end
            // a span that wrote nothing reports all-zero fields apart from image_done
            if (sp.span_length == 8'd0) begin
                sp = '0;
            end
            sp.image_done = done;
            o_has_span    = (sp.span_length != 8'd0) || done;
            if (done) begin
                if (i_last) begin
                    st = STATE_RESET;
                end else begin
                    st.phase = PH_DONE;
                end
            end
        end
    end

    assign o_state = st;
    assign o_span  = sp;

endmodule

// File: design/bitmap_rle_decoder.sv
// Bitmap RLE8/RLE4 stream decoder: takes one compressed byte per request and
// returns at most one pixel span per byte. A byte is accepted every cycle while
// the span output is not stalled; the byte is captured in the input register
// when accepted, and one parse step through brle_step then loads the span into
// the result register, which presents it. The sustained rate of one byte per
// cycle while the output is not stalled is set by the parser state recurrence,
// which brle_step closes combinationally. The user must write configuration
// registers only while no request is in flight; the block does not enforce it.
// Depends on brle_pkg, brle_in_if, brle_out_if, brle_cfg_if and brle_step.
module bitmap_rle_decoder (
    input  logic       i_clk,
    input  logic       i_rst_n,
    brle_in_if.sink    i_in,
    brle_out_if.source o_out,
    brle_cfg_if.sink   i_cfg
);
    import brle_pkg::*;

    logic        r_in_valid;
    logic [7:0]  r_byte;
    logic        r_last;
    t_state      r_state;
    t_state      n_state;
    logic [12:0] r_width;
    logic [12:0] r_height;
    logic        r_mode;
    logic        r_out_valid;
    t_span       r_out;
    t_span       n_out;
    logic        n_has;
    logic        proceed;

    // advance the parser when the result register is free or draining
    assign proceed     = r_in_valid && (!r_out_valid || o_out.ready);
    assign i_in.ready  = !r_in_valid || proceed;
    assign i_cfg.ready = 1'b1;

    brle_step u_step (
        .i_state    (r_state),
        .i_width    (r_width),
        .i_height   (r_height),
        .i_mode     (r_mode),
        .i_byte     (r_byte),
        .i_last     (r_last),
        .o_state    (n_state),
        .o_span     (n_out),
        .o_has_span (n_has)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_state     <= STATE_RESET;
            r_width     <= 13'd1;
            r_height    <= 13'd1;
            r_mode      <= 1'b0;
        end else begin
            if (i_in.valid && i_in.ready) begin
                r_in_valid <= 1'b1;
            end else if (proceed) begin
                r_in_valid <= 1'b0;
            end

            if (proceed) begin
                r_state     <= n_state;
                r_out_valid <= n_has;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end

            if (i_cfg.valid && i_cfg.ready) begin
                case (i_cfg.cfg_index)
                    CFG_IMAGE_WIDTH:  r_width  <= i_cfg.cfg_data;
                    CFG_IMAGE_HEIGHT: r_height <= i_cfg.cfg_data;
                    CFG_PIXEL_MODE:   r_mode   <= i_cfg.cfg_data[0];
                    default: begin
                        // unknown index: drop the write
                    end
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in.valid && i_in.ready) begin
            r_byte <= i_in.stream_byte;
            r_last <= i_in.last_byte;
        end
        if (proceed && n_has) begin
            r_out <= n_out;
        end
    end

    assign o_out.valid       = r_out_valid;
    assign o_out.span_column = r_out.span_column;
    assign o_out.span_row    = r_out.span_row;
    assign o_out.span_length = r_out.span_length;
    assign o_out.even_index  = r_out.even_index;
    assign o_out.odd_index   = r_out.odd_index;
    assign o_out.image_done  = r_out.image_done;

    a_empty_span_is_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && (r_out.span_length == 8'd0) |-> r_out.image_done)
        else $error("empty span without image_done");

    a_span_fits_row: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && (r_out.span_length != 8'd0) |->
            (({1'b0, r_out.span_column} + {5'd0, r_out.span_length})
                <= eff_limit(r_width, MAX_WIDTH)))
        else $error("span runs past the image width");

    a_done_parks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        proceed && n_has && n_out.image_done && !r_last |=> (r_state.phase == PH_DONE))
        else $error("parser not parked after image end");

    a_silent_after_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        proceed && (r_state.phase == PH_DONE) |=> !r_out_valid || $stable(r_out))
        else $error("result produced after image end");

endmodule

// File: verif/bitmap_rle_decoder_tb.sv
// Self-checking testbench for bitmap_rle_decoder: drives RLE8/RLE4 byte streams,
// predicts every pixel span and compares it field by field at the span output.
// Depends on bitmap_rle_decoder, brle_pkg and the brle_in_if, brle_out_if and brle_cfg_if interfaces.
module bitmap_rle_decoder_tb;
    timeunit 1ns;
    timeprecision 1ps;
    import brle_pkg::*;

    logic i_clk;
    logic i_rst_n;

    brle_in_if  byte_ch ();
    brle_out_if span_ch ();
    brle_cfg_if reg_ch ();

    bitmap_rle_decoder DUT (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (byte_ch),
        .o_out   (span_ch),
        .i_cfg   (reg_ch)
    );

    // predicted decoder: registers and parse state
    int unsigned cfg_width  = 1;
    int unsigned cfg_height = 1;
    bit          cfg_rle4   = 1'b0;

    t_phase      dec_phase    = PH_COUNT;
    int unsigned dec_count    = 0;
    int unsigned dec_col      = 0;
    int unsigned dec_row      = 0;
    int unsigned dec_abs_left = 0;
    bit          dec_pad      = 1'b0;
    int unsigned dec_dx       = 0;

    t_span       expected_spans[$];
    logic [7:0]  stream_bytes[$];
    int unsigned decoded_items  = 0;
    int unsigned mismatch_count = 0;

    bit          in_quiet   = 1'b0;
    bit          out_quiet  = 1'b0;
    bit          drain_next = 1'b0;
    int unsigned span_hold  = 0;

    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    initial begin
        #10_000_000;
        $display("Simulation FAILED");
        $finish;
    end

    function automatic void rearm_decoder();
        dec_phase    = PH_COUNT;
        dec_count    = 0;
        dec_col      = 0;
        dec_row      = 0;
        dec_abs_left = 0;
        dec_pad      = 1'b0;
        dec_dx       = 0;
    endfunction

    // pixels of an n-pixel span that still fit in the row
    function automatic int unsigned room_for(input int unsigned n);
        int unsigned w;
        w = (cfg_width > MAX_WIDTH) ? MAX_WIDTH : cfg_width;
        if (dec_col >= w) return 0;
        return (n < w - dec_col) ? n : w - dec_col;
    endfunction

    function automatic bit decode_byte(input logic [7:0] b, input logic last,
                                       output t_span span);
        int unsigned w, h, len, col, row, ev, od, n;
        bit done;
        w    = (cfg_width > MAX_WIDTH) ? MAX_WIDTH : cfg_width;
        h    = (cfg_height > MAX_HEIGHT) ? MAX_HEIGHT : cfg_height;
        len  = 0;
        col  = 0;
        row  = 0;
        ev   = 0;
        od   = 0;
        done = 1'b0;
        span = '0;
        if (dec_phase == PH_DONE) begin
            if (last) rearm_decoder();
            return 1'b0;
        end
        if (dec_row >= h) begin
            done = 1'b1;
        end else begin
            case (dec_phase)
                PH_COUNT: begin
                    dec_count = b;
                    dec_phase = PH_CMD;
                end
                PH_CMD: begin
                    dec_phase = PH_COUNT;
                    if (dec_count != 0) begin
                        col = dec_col;
                        row = dec_row;
                        len = room_for(dec_count);
                        ev  = cfg_rle4 ? (b >> 4) & NIBBLE_MASK : b;
                        od  = cfg_rle4 ? b & NIBBLE_MASK : b;
                        dec_col += len;
                    end else if (b == ESC_END_LINE) begin
                        dec_col = 0;
                        dec_row++;
                        if (dec_row >= h) done = 1'b1;
                    end else if (b == ESC_END_IMAGE) begin
                        done = 1'b1;
                    end else if (b == ESC_DELTA) begin
                        dec_phase = PH_DX;
                    end else begin
                        dec_abs_left = b;
                        // pad follows when the group takes an odd number of bytes
                        dec_pad   = cfg_rle4 ? (b[1] ^ b[0]) : b[0];
                        dec_phase = PH_ABS;
                    end
                end
                PH_DX: begin
                    dec_dx    = b;
                    dec_phase = PH_DY;
                end
                PH_DY: begin
                    dec_col = (dec_col + dec_dx > w) ? w : dec_col + dec_dx;
                    dec_row += b;
                    if (dec_row >= h) begin
                        dec_row = h;
                        done    = 1'b1;
                    end
                    dec_phase = PH_COUNT;
                end
                PH_ABS: begin
                    n  = cfg_rle4 ? ((dec_abs_left < 2) ? dec_abs_left : 2) : 1;
                    ev = cfg_rle4 ? (b >> 4) & NIBBLE_MASK : b;
                    od = cfg_rle4 ? b & NIBBLE_MASK : b;
                    col = dec_col;
                    row = dec_row;
                    len = room_for(n);
                    dec_col += len;
                    dec_abs_left = (dec_abs_left >= n) ? dec_abs_left - n : 0;
                    if (dec_abs_left == 0) dec_phase = dec_pad ? PH_PAD : PH_COUNT;
                end
                default: begin
                    dec_phase = PH_COUNT;
                end
            endcase
        end
        if (last) done = 1'b1;
        if (len == 0 && !done) return 1'b0;
        if (len == 0) begin
            col = 0;
            row = 0;
            ev  = 0;
            od  = 0;
        end
        span.span_column = col[11:0];
        span.span_row    = row[11:0];
        span.span_length = len[7:0];
        span.even_index  = ev[7:0];
        span.odd_index   = od[7:0];
        span.image_done  = done;
        if (done) begin
            if (last) rearm_decoder();
            else dec_phase = PH_DONE;
        end
        return 1'b1;
    endfunction

    function automatic void check_field(input string name, input int unsigned want,
                                        input int unsigned got);
        if (want != got) begin
            $error("%s: expected %0d, actual %0d", name, want, got);
            mismatch_count++;
        end
    endfunction

    // sample all three channels at the edge; predict on every accepted byte
    always @(posedge i_clk) begin
        t_span want;
        if (i_rst_n) begin
            if (span_ch.valid && span_ch.ready) begin
                if (expected_spans.size() == 0) begin
                    $error("span with no expected value: column %0d row %0d length %0d",
                           span_ch.span_column, span_ch.span_row, span_ch.span_length);
                    mismatch_count++;
                end else begin
                    want = expected_spans.pop_front();
                    check_field("span_column", want.span_column, span_ch.span_column);
                    check_field("span_row", want.span_row, span_ch.span_row);
                    check_field("span_length", want.span_length, span_ch.span_length);
                    check_field("even_index", want.even_index, span_ch.even_index);
                    check_field("odd_index", want.odd_index, span_ch.odd_index);
                    check_field("image_done", want.image_done, span_ch.image_done);
                end
            end
            if (reg_ch.valid && reg_ch.ready) begin
                case (reg_ch.cfg_index)
                    CFG_IMAGE_WIDTH:  cfg_width  = reg_ch.cfg_data;
                    CFG_IMAGE_HEIGHT: cfg_height = reg_ch.cfg_data;
                    CFG_PIXEL_MODE:   cfg_rle4   = reg_ch.cfg_data[0];
                    default: ;
                endcase
            end
            if (byte_ch.valid && byte_ch.ready) begin
                decoded_items++;
                if (decode_byte(byte_ch.stream_byte, byte_ch.last_byte, want))
                    expected_spans.push_back(want);
            end
        end
    end

    // span receiver: random stall per request, plus a long hold-off on demand
    initial begin : span_sink
        int unsigned gap;
        span_ch.ready <= 1'b0;
        @(posedge i_clk);
        forever begin
            if (span_hold != 0) begin
                span_ch.ready <= 1'b0;
                repeat (span_hold) @(posedge i_clk);
                span_hold = 0;
            end
            gap = out_quiet ? 0 : $urandom_range(0, 17);
            if (gap != 0) begin
                span_ch.ready <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
            span_ch.ready <= 1'b1;
            @(posedge i_clk);
            while (!span_ch.valid) @(posedge i_clk);
        end
    end

    // valid stays high after the request; the next call lowers it when it idles
    task automatic send_byte(input logic [7:0] b, input logic last);
        int unsigned gap;
        gap = in_quiet ? 0 : $urandom_range(0, 17);
        if (drain_next || (!in_quiet && $urandom_range(0, 99) == 0)) begin
            drain_next = 1'b0;
            byte_ch.valid <= 1'b0;
            @(posedge i_clk);
            while (expected_spans.size() != 0) @(posedge i_clk);
        end else if (gap != 0) begin
            byte_ch.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        byte_ch.valid       <= 1'b1;
        byte_ch.stream_byte <= b;
        byte_ch.last_byte   <= last;
        @(posedge i_clk);
        while (!byte_ch.ready) @(posedge i_clk);
    endtask

    task automatic send_stream();
        foreach (stream_bytes[i]) send_byte(stream_bytes[i], i == stream_bytes.size() - 1);
        stream_bytes.delete();
    endtask

    // caller has already dropped byte_ch.valid
    task automatic wait_idle();
        @(posedge i_clk);
        while (expected_spans.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic write_reg(input t_cfg_index idx, input t_cfg_data data);
        reg_ch.valid     <= 1'b1;
        reg_ch.cfg_index <= idx;
        reg_ch.cfg_data  <= data;
        @(posedge i_clk);
        while (!reg_ch.ready) @(posedge i_clk);
    endtask

    task automatic set_config(input int unsigned width, input int unsigned height,
                              input bit rle4);
        write_reg(CFG_IMAGE_WIDTH, width[12:0]);
        write_reg(CFG_IMAGE_HEIGHT, height[12:0]);
        write_reg(CFG_PIXEL_MODE, {12'd0, rle4});
        reg_ch.valid <= 1'b0;
    endtask

    task automatic test_rle8_escapes();
        set_config(6, 3, 1'b0);
        // absolute group with pad, clipped run, absolute group past the edge,
        // saturating delta, end of image, ignored byte, rearming last byte
        stream_bytes = '{8'd0, 8'd3, 8'h80, 8'h01, 8'h7F, 8'h00,
                         8'd5, 8'hFF,
                         8'd0, 8'd3, 8'h11, 8'h22, 8'h33, 8'hEE,
                         8'd0, ESC_DELTA, 8'd9, 8'd1,
                         8'd0, ESC_END_IMAGE, 8'h55, 8'hAA};
        send_stream();
        byte_ch.valid <= 1'b0;
        wait_idle();
    endtask

    task automatic test_rle4_nibbles();
        set_config(9, 2, 1'b1);
        // odd nibble groups with and without pad; second end of line hits the height
        stream_bytes = '{8'd5, 8'h3C,
                         8'd0, 8'd5, 8'h12, 8'h34, 8'h56, 8'h00,
                         8'd0, ESC_END_LINE,
                         8'd0, 8'd3, 8'hAB, 8'hCD,
                         8'd0, ESC_END_LINE};
        send_stream();
        byte_ch.valid <= 1'b0;
        wait_idle();
    endtask

    task automatic test_zero_height();
        set_config(4, 0, 1'b0);
        send_byte(8'h10, 1'b0);
        send_byte(8'hF0, 1'b1);
        byte_ch.valid <= 1'b0;
        wait_idle();
    endtask

    task automatic test_far_corner();
        set_config(8191, 4096, 1'b0);
        repeat (16) begin
            stream_bytes.push_back(8'd0);
            stream_bytes.push_back(ESC_DELTA);
            stream_bytes.push_back(8'd255);
            stream_bytes.push_back(8'd255);
        end
        // land on the last pixel, clip there, then overshoot the bottom
        stream_bytes = {stream_bytes, 8'd0, ESC_DELTA, 8'd15, 8'd15,
                        8'd5, 8'hA5, 8'd3, 8'h5A,
                        8'd0, ESC_DELTA, 8'd255, 8'd255, 8'h33, 8'h44};
        send_stream();
        byte_ch.valid <= 1'b0;
        wait_idle();
    endtask

    task automatic test_output_stall();
        set_config(4096, 4096, 1'b0);
        span_hold = 300;
        in_quiet  = 1'b1;
        repeat (40) begin
            send_byte(8'($urandom_range(1, 20)), 1'b0);
            send_byte(8'($urandom_range(0, 255)), 1'b0);
        end
        send_byte(8'd0, 1'b0);
        send_byte(ESC_END_IMAGE, 1'b1);
        in_quiet = 1'b0;
        byte_ch.valid <= 1'b0;
        wait_idle();
    endtask

    task automatic test_random_streams();
        int unsigned target, width, height, n, nbytes;
        bit rle4;
        target     = decoded_items + 1300;
        drain_next = 1'b1;
        while (decoded_items < target) begin
            case ($urandom_range(0, 15))
                0:       width = 0;
                1:       width = 1;
                2:       width = 4096;
                3:       width = 8191;
                default: width = $urandom_range(2, 48);
            endcase
            case ($urandom_range(0, 11))
                0:       height = 0;
                1:       height = 4096;
                2:       height = 8191;
                default: height = $urandom_range(1, 8);
            endcase
            rle4      = 1'($urandom_range(0, 1));
            in_quiet  = ($urandom_range(0, 5) == 0);
            out_quiet = ($urandom_range(0, 5) == 0);
            set_config(width, height, rle4);
            repeat ($urandom_range(1, 4)) begin
                repeat ($urandom_range(1, 12)) begin
                    case ($urandom_range(0, 11))
                        0, 1, 2, 3: begin
                            stream_bytes.push_back(8'($urandom_range(1, 12)));
                            stream_bytes.push_back(8'($urandom_range(0, 255)));
                        end
                        4, 5, 6: begin
                            n = ($urandom_range(0, 9) == 0) ? $urandom_range(3, 255)
                                                            : $urandom_range(3, 16);
                            nbytes = rle4 ? (n + 1) / 2 : n;
                            stream_bytes.push_back(8'd0);
                            stream_bytes.push_back(n[7:0]);
                            repeat (nbytes) stream_bytes.push_back(8'($urandom_range(0, 255)));
                            if (nbytes % 2 != 0)
                                stream_bytes.push_back(8'($urandom_range(0, 255)));
                        end
                        7: begin
                            stream_bytes.push_back(8'd0);
                            stream_bytes.push_back(ESC_END_LINE);
                        end
                        8: begin
                            stream_bytes.push_back(8'd0);
                            stream_bytes.push_back(ESC_DELTA);
                            stream_bytes.push_back(($urandom_range(0, 7) == 0) ? 8'd255
                                                   : 8'($urandom_range(0, 15)));
                            stream_bytes.push_back(($urandom_range(0, 7) == 0)
                                                   ? 8'($urandom_range(3, 255))
                                                   : 8'($urandom_range(0, 1)));
                        end
                        9: begin
                            // stray byte: knock the pairs out of step
                            stream_bytes.push_back(8'($urandom_range(0, 255)));
                        end
                        default: begin
                            stream_bytes.push_back(($urandom_range(0, 1) == 0) ? 8'd255
                                                   : 8'($urandom_range(13, 254)));
                            stream_bytes.push_back(8'($urandom_range(0, 255)));
                        end
                    endcase
                end
                case ($urandom_range(0, 3))
                    1: begin
                        stream_bytes.push_back(8'd0);
                        stream_bytes.push_back(ESC_END_IMAGE);
                    end
                    2: begin
                        stream_bytes.push_back(8'd0);
                        stream_bytes.push_back(ESC_END_IMAGE);
                        repeat ($urandom_range(1, 3))
                            stream_bytes.push_back(8'($urandom_range(0, 255)));
                    end
                    3: stream_bytes.push_back(8'($urandom_range(0, 255)));
                    default: ;
                endcase
                send_stream();
            end
            byte_ch.valid <= 1'b0;
            wait_idle();
        end
        in_quiet  = 1'b0;
        out_quiet = 1'b0;
    endtask

    initial begin
        byte_ch.valid       <= 1'b0;
        byte_ch.stream_byte <= 8'd0;
        byte_ch.last_byte   <= 1'b0;
        reg_ch.valid        <= 1'b0;
        reg_ch.cfg_index    <= CFG_IMAGE_WIDTH;
        reg_ch.cfg_data     <= '0;
        i_rst_n             <= 1'b0;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_rle8_escapes();
        test_rle4_nibbles();
        test_zero_height();
        test_far_corner();
        test_output_stall();
        test_random_streams();

        wait_idle();
        if (mismatch_count == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule
